// ----- rtl/clsr_pkg.sv -----
package clsr_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int VALUE_W   = 32;
  localparam int STEPS_W   = 16;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 11;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Strobes from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic set_full;
    logic set_empty;
    logic alloc_read;
    logic alloc_fresh;
    logic take_slot;
    logic push_link;
    logic push_tie;
    logic mod_init;
    logic mod_step;
    logic take_cursor;
    logic walk_start;
    logic walk_step;
    logic unlink;
    logic load_out;
  } dp_cmd_t;

  // Conditions from the datapath back to the controller.
  typedef struct packed {
    logic cmd_pop;
    logic count_zero;
    logic count_one;
    logic count_full;
    logic rc_zero;
    logic mod_last;
    logic rem_zero;
    logic walk_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/clsr_ram.sv -----
module clsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/clsr_ctrl.sv -----
module clsr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  clsr_pkg::dp_stat_t stat,
  output clsr_pkg::dp_cmd_t  cmd
);

  import clsr_pkg::*;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DECODE     = 4'd1;
  localparam logic [3:0] S_PUSH_SLOT  = 4'd2;
  localparam logic [3:0] S_PUSH_LINK  = 4'd3;
  localparam logic [3:0] S_PUSH_TIE   = 4'd4;
  localparam logic [3:0] S_MOD        = 4'd5;
  localparam logic [3:0] S_WALK_START = 4'd6;
  localparam logic [3:0] S_WALK       = 4'd7;
  localparam logic [3:0] S_UNLINK_RD  = 4'd8;
  localparam logic [3:0] S_UNLINK     = 4'd9;
  localparam logic [3:0] S_DONE       = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // No beat is taken while reset is held.
  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.cmd_pop) begin
          if (stat.count_full) begin
            cmd.set_full = 1'b1;
            state_next   = S_DONE;
          end else if (!stat.rc_zero) begin
            cmd.alloc_read = 1'b1;
            state_next     = S_PUSH_SLOT;
          end else begin
            cmd.alloc_fresh = 1'b1;
            state_next      = S_PUSH_LINK;
          end
        end else begin
          if (stat.count_zero) begin
            cmd.set_empty = 1'b1;
            state_next    = S_DONE;
          end else if (stat.count_one) begin
            cmd.take_cursor = 1'b1;
            state_next      = S_UNLINK_RD;
          end else begin
            cmd.mod_init = 1'b1;
            state_next   = S_MOD;
          end
        end
      end
      S_PUSH_SLOT: begin
        cmd.take_slot = 1'b1;
        state_next    = S_PUSH_LINK;
      end
      S_PUSH_LINK: begin
        cmd.push_link = 1'b1;
        state_next    = stat.count_zero ? S_DONE : S_PUSH_TIE;
      end
      S_PUSH_TIE: begin
        cmd.push_tie = 1'b1;
        state_next   = S_DONE;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_next = S_WALK_START;
        end
      end
      S_WALK_START: begin
        cmd.walk_start = 1'b1;
        state_next     = stat.rem_zero ? S_UNLINK_RD : S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          state_next = S_UNLINK_RD;
        end
      end
      S_UNLINK_RD: begin
        state_next = S_UNLINK;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/clsr_dp.sv -----
module clsr_dp #(
  parameter int CAPACITY   = clsr_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = clsr_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  clsr_pkg::dp_cmd_t              cmd,
  output clsr_pkg::dp_stat_t             stat,
  input  logic                           command,
  input  logic [clsr_pkg::VALUE_W-1:0]   value,
  input  logic [clsr_pkg::STEPS_W-1:0]   steps,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [clsr_pkg::VALUE_W-1:0]   removed_value,
  output logic [clsr_pkg::STATUS_W-1:0]  status,
  output logic [clsr_pkg::ENTRIES_W-1:0] entries
);

  import clsr_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int BIT_W  = $clog2(STEPS_W);

  // List registers.
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;
  logic [SLOT_W-1:0] cursor;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  fresh;
  logic [CNT_W-1:0]  rc;

  // Item registers.
  logic                  cmd_reg;
  logic [VALUE_W-1:0]    value_reg;
  logic [STEPS_W-1:0]    shreg;
  logic [BIT_W-1:0]      bitcnt;
  logic [CNT_W-1:0]      rem;
  logic [CNT_W-1:0]      left;
  logic [SLOT_W-1:0]     slot;
  logic [SLOT_W-1:0]     d;
  logic [DATA_WIDTH-1:0] res_removed;
  logic [STATUS_W-1:0]   res_status;

  // Memory ports.
  logic                  next_we;
  logic [SLOT_W-1:0]     next_waddr;
  logic [SLOT_W-1:0]     next_wdata;
  logic [SLOT_W-1:0]     next_raddr;
  logic [SLOT_W-1:0]     next_rdata;
  logic                  prev_we;
  logic [SLOT_W-1:0]     prev_waddr;
  logic [SLOT_W-1:0]     prev_wdata;
  logic [SLOT_W-1:0]     prev_rdata;
  logic [DATA_WIDTH-1:0] pay_rdata;
  logic [SLOT_W-1:0]     rec_raddr;
  logic [SLOT_W-1:0]     rec_rdata;
  logic [CNT_W-1:0]      rc_dec;
  logic [CNT_W:0]        trial;

  assign rc_dec    = rc - CNT_W'(1);
  assign rec_raddr = rc_dec[SLOT_W-1:0];
  // One bit of the restoring remainder steps mod count.
  assign trial     = {rem, shreg[STEPS_W-1]};

  assign stat.cmd_pop    = (cmd_reg == CMD_POP);
  assign stat.count_zero = (count == '0);
  assign stat.count_one  = (count == CNT_W'(1));
  assign stat.count_full = (count == CNT_W'(CAPACITY));
  assign stat.rc_zero    = (rc == '0);
  assign stat.mod_last   = (bitcnt == BIT_W'(STEPS_W - 1));
  assign stat.rem_zero   = (rem == '0);
  assign stat.walk_last  = (left == CNT_W'(1));
  assign stat.out_free   = !out_valid || out_ready;

  // The walk feeds each read result straight back as the next address.
  always_comb begin
    if (cmd.walk_start) begin
      next_raddr = cursor;
    end else if (cmd.walk_step) begin
      next_raddr = next_rdata;
    end else begin
      next_raddr = d;
    end
  end

  always_comb begin
    next_we    = 1'b0;
    next_waddr = slot;
    next_wdata = slot;
    prev_we    = 1'b0;
    prev_waddr = slot;
    prev_wdata = slot;
    if (cmd.push_link) begin
      next_we    = 1'b1;
      next_wdata = stat.count_zero ? slot : head;
      prev_we    = 1'b1;
      prev_wdata = stat.count_zero ? slot : tail;
    end else if (cmd.push_tie) begin
      next_we    = 1'b1;
      next_waddr = tail;
      prev_we    = 1'b1;
      prev_waddr = head;
    end else if (cmd.unlink && !stat.count_one) begin
      next_we    = 1'b1;
      next_waddr = prev_rdata;
      next_wdata = next_rdata;
      prev_we    = 1'b1;
      prev_waddr = next_rdata;
      prev_wdata = prev_rdata;
    end
  end

  clsr_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_next (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (next_raddr),
    .rdata (next_rdata)
  );

  clsr_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_prev (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (d),
    .rdata (prev_rdata)
  );

  clsr_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_payload (
    .clk   (clk),
    .we    (cmd.push_link),
    .waddr (slot),
    .wdata (DATA_WIDTH'(value_reg)),
    .raddr (d),
    .rdata (pay_rdata)
  );

  clsr_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_recycle (
    .clk   (clk),
    .we    (cmd.unlink),
    .waddr (rc[SLOT_W-1:0]),
    .wdata (d),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      cursor <= '0;
      count  <= '0;
      fresh  <= '0;
      rc     <= '0;
    end else begin
      if (cmd.alloc_read) begin
        rc <= rc_dec;
      end else if (cmd.unlink) begin
        rc <= rc + CNT_W'(1);
      end
      if (cmd.alloc_fresh) begin
        fresh <= fresh + CNT_W'(1);
      end
      if (cmd.push_link && stat.count_zero) begin
        head   <= slot;
        tail   <= slot;
        cursor <= slot;
        count  <= count + CNT_W'(1);
      end
      if (cmd.push_tie) begin
        tail  <= slot;
        count <= count + CNT_W'(1);
      end
      if (cmd.unlink) begin
        if (stat.count_one) begin
          head   <= '0;
          tail   <= '0;
          cursor <= '0;
          count  <= '0;
        end else begin
          cursor <= next_rdata;
          if (d == head) begin
            head <= next_rdata;
          end else if (d == tail) begin
            tail <= prev_rdata;
          end
          count <= count - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_reg     <= command;
      value_reg   <= value;
      shreg       <= steps;
      res_removed <= '0;
      res_status  <= STATUS_OK;
    end
    if (cmd.set_full) begin
      res_status <= STATUS_FULL;
    end
    if (cmd.set_empty) begin
      res_status <= STATUS_EMPTY;
    end
    if (cmd.alloc_fresh) begin
      slot <= fresh[SLOT_W-1:0];
    end
    if (cmd.take_slot) begin
      slot <= rec_rdata;
    end
    if (cmd.mod_init) begin
      rem    <= '0;
      bitcnt <= '0;
    end
    if (cmd.mod_step) begin
      if (trial >= {1'b0, count}) begin
        rem <= CNT_W'(trial - {1'b0, count});
      end else begin
        rem <= trial[CNT_W-1:0];
      end
      shreg  <= {shreg[STEPS_W-2:0], 1'b0};
      bitcnt <= bitcnt + BIT_W'(1);
    end
    if (cmd.take_cursor || cmd.walk_start) begin
      d <= cursor;
    end
    if (cmd.walk_start) begin
      left <= rem;
    end
    if (cmd.walk_step) begin
      d    <= next_rdata;
      left <= left - CNT_W'(1);
    end
    if (cmd.unlink) begin
      res_removed <= pay_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      removed_value <= VALUE_W'(res_removed);
      status        <= res_status;
      entries       <= ENTRIES_W'(count);
    end
  end

endmodule

// ----- rtl/circular_list_step_removal_core.sv -----
// Push: decode, link and, onto a non-empty list, tie; a recycled slot is read before the
// link. Pop: a one-entry list goes from decode to the unlink; else a bit-serial remainder
// finds steps mod entries, then the walk reads one next link per cycle. Pop on an empty
// list or push on a full one goes from decode to done. One item is in flight at a time;
// the result waits until the output is free, and the next beat is taken once it is
// registered. Synchronous reset empties the list; slot memories stay as is.
module circular_list_step_removal_core #(
  parameter int CAPACITY   = clsr_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = clsr_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic [clsr_pkg::VALUE_W-1:0]   value,
  input  logic [clsr_pkg::STEPS_W-1:0]   steps,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [clsr_pkg::VALUE_W-1:0]   removed_value,
  output logic [clsr_pkg::STATUS_W-1:0]  status,
  output logic [clsr_pkg::ENTRIES_W-1:0] entries
);

  import clsr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  clsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  clsr_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .command       (command),
    .value         (value),
    .steps         (steps),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .removed_value (removed_value),
    .status        (status),
    .entries       (entries)
  );

endmodule
